// ----- rtl/core/gost_bc_pkg.sv -----
`timescale 1ns / 1ps

package gost_bc_pkg;

    localparam int NUM_ROUNDS = 32;
    localparam int NUM_KEYS   = 8;
    localparam int ROT_LEFT   = 11;
    localparam int CFG_IDX_W  = 4;

    // Mode codes carried on the input tuser
    typedef enum logic [2:0] {
        MODE_ECB_ENC = 3'd0,
        MODE_ECB_DEC = 3'd1,
        MODE_CBC_ENC = 3'd2,
        MODE_CBC_DEC = 3'd3,
        MODE_LOAD_IV = 3'd4
    } t_mode;

    // One word moving down the row of round cells
    typedef struct packed {
        logic        vld;
        logic        dec;
        logic        cbc_enc;
        logic        cbc_dec;
        logic [63:0] chain;
        logic [31:0] a;      // half fed into the round function
        logic [31:0] b;      // half that takes the XOR
    } t_cell_word;

    typedef logic [3:0] t_sbox [8][16];

    localparam t_sbox SBOX = '{
        '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
          4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7},
        '{4'd15, 4'd1,  4'd8,  4'd14, 4'd6,  4'd11, 4'd3,  4'd4,
          4'd9,  4'd7,  4'd2,  4'd13, 4'd12, 4'd0,  4'd5,  4'd10},
        '{4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
          4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8},
        '{4'd7,  4'd13, 4'd14, 4'd3,  4'd0,  4'd6,  4'd9,  4'd10,
          4'd1,  4'd2,  4'd8,  4'd5,  4'd11, 4'd12, 4'd4,  4'd15},
        '{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
          4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9},
        '{4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
          4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11},
        '{4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
          4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1},
        '{4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
          4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7}
    };

    // Substitute the eight nibbles, then rotate left; the top nibble uses row 0
    function automatic logic [31:0] round_fn(input logic [31:0] x);
        logic [31:0] w;
        for (int j = 0; j < 8; j++) begin
            w[4*j +: 4] = SBOX[7-j][x[4*j +: 4]];
        end
        return {w[31-ROT_LEFT:0], w[31:32-ROT_LEFT]};
    endfunction

    // Key word used at a round: 24 forward then 8 reversed for encrypt,
    // 8 forward then 24 reversed for decrypt
    function automatic logic [2:0] key_index(input int rnd, input logic dec);
        logic fwd;
        logic [2:0] pos;
        fwd = dec ? (rnd < 8) : (rnd < 24);
        pos = 3'(rnd % NUM_KEYS);
        return fwd ? pos : 3'(NUM_KEYS - 1) - pos;
    endfunction

endpackage

// ----- rtl/core/gost_bc_round_cell.sv -----
`timescale 1ns / 1ps

module gost_bc_round_cell
    import gost_bc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_cell_word  i_word,
    input  logic [31:0] i_key_enc,
    input  logic [31:0] i_key_dec,
    output t_cell_word  o_word
);

    t_cell_word  r_word;
    t_cell_word  n_word;
    logic [31:0] key;
    logic [31:0] sum;

    // One Feistel round: add key, substitute, rotate, mix and swap halves
    always_comb begin
        key    = i_word.dec ? i_key_dec : i_key_enc;
        sum    = i_word.a + key;
        n_word = i_word;
        n_word.a = i_word.b ^ round_fn(sum);
        n_word.b = i_word.a;
    end

    // Advance when the row moves; only the valid bit needs reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.vld <= 1'b0;
        end else if (i_en) begin
            r_word.vld <= n_word.vld;
        end
        if (i_en) begin
            r_word.dec     <= n_word.dec;
            r_word.cbc_enc <= n_word.cbc_enc;
            r_word.cbc_dec <= n_word.cbc_dec;
            r_word.chain   <= n_word.chain;
            r_word.a       <= n_word.a;
            r_word.b       <= n_word.b;
        end
    end

    assign o_word = r_word;

endmodule

// ----- rtl/core/gost_block_cipher_ecb_cbc.sv -----
`timescale 1ns / 1ps

// GOST 28147-89 block cipher, ECB and CBC, one round per cell in a row of 32
// cells plus an output register. ECB encrypt, ECB decrypt and CBC decrypt take
// one 64-bit word per cycle unless the output is held. A CBC encrypt word needs
// the previous CBC encrypt result, so while one is in the row, any further CBC
// encrypt, CBC decrypt or IV-load word waits until it leaves the last cell:
// CBC encryption takes a new word only once the last one is through the row.
// The user must write key words on the configuration channel only while the
// engine is idle; the block does not enforce this. Mode 4 loads the chaining
// value and gives no output; modes 5 to 7 are taken and dropped.
module gost_block_cipher_ecb_cbc
    import gost_bc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // key word write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [63:0]          s_axis_tdata,  // [63:0] block_in
    input  logic [2:0]           s_axis_tuser,  // [2:0] mode
    // output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata   // [63:0] block_out
);

    logic [31:0] r_key [NUM_KEYS];
    logic [63:0] r_chain;
    logic [63:0] n_chain;
    logic        r_pending;
    logic        n_pending;
    logic        r_out_valid;
    logic [63:0] r_out_data;

    logic        adv;
    logic        in_acc;
    logic        chain_use;
    logic [63:0] res;
    logic        exit_enc;
    t_mode       mode;
    t_cell_word  w [NUM_ROUNDS+1];

    // Key registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_key[k] <= '0;
            end
        end else if (i_cfg_valid && (i_cfg_index < CFG_IDX_W'(NUM_KEYS))) begin
            r_key[i_cfg_index[2:0]] <= i_cfg_data;
        end
    end

    // Hold the row while the output word is not taken
    assign adv  = !r_out_valid || m_axis_tready;
    assign mode = t_mode'(s_axis_tuser);

    always_comb begin
        case (mode)
            MODE_CBC_ENC, MODE_CBC_DEC, MODE_LOAD_IV: chain_use = 1'b1;
            default:                                  chain_use = 1'b0;
        endcase
    end

    // Stall chain-value users while a CBC encrypt word is in the row
    assign s_axis_tready = adv && !(r_pending && chain_use);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Build the word entering the first cell
    always_comb begin
        w[0]         = '0;
        w[0].chain   = r_chain;
        w[0].a       = s_axis_tdata[31:0];
        w[0].b       = s_axis_tdata[63:32];
        case (mode)
            MODE_ECB_ENC: begin
                w[0].vld = in_acc;
            end
            MODE_ECB_DEC: begin
                w[0].vld = in_acc;
                w[0].dec = 1'b1;
            end
            MODE_CBC_ENC: begin
                w[0].vld     = in_acc;
                w[0].cbc_enc = 1'b1;
                w[0].a       = s_axis_tdata[31:0] ^ r_chain[31:0];
                w[0].b       = s_axis_tdata[63:32] ^ r_chain[63:32];
            end
            MODE_CBC_DEC: begin
                w[0].vld     = in_acc;
                w[0].dec     = 1'b1;
                w[0].cbc_dec = 1'b1;
            end
            default: begin
                w[0].vld = 1'b0;
            end
        endcase
    end

    // Row of round cells
    for (genvar s = 0; s < NUM_ROUNDS; s++) begin : g_cell
        localparam logic [2:0] KE = key_index(s, 1'b0);
        localparam logic [2:0] KD = key_index(s, 1'b1);

        gost_bc_round_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (adv),
            .i_word    (w[s]),
            .i_key_enc (r_key[KE]),
            .i_key_dec (r_key[KD]),
            .o_word    (w[s+1])
        );
    end

    // Final word: n2 low, n1 high, then the CBC decrypt XOR
    assign res      = {w[NUM_ROUNDS].a, w[NUM_ROUNDS].b}
                    ^ (w[NUM_ROUNDS].cbc_dec ? w[NUM_ROUNDS].chain : 64'd0);
    assign exit_enc = adv && w[NUM_ROUNDS].vld && w[NUM_ROUNDS].cbc_enc;

    // Chaining value and the in-flight CBC encrypt flag
    always_comb begin
        n_chain   = r_chain;
        n_pending = r_pending;
        if (exit_enc) begin
            n_chain   = res;
            n_pending = 1'b0;
        end
        if (in_acc) begin
            case (mode)
                MODE_CBC_ENC:               n_pending = 1'b1;
                MODE_CBC_DEC, MODE_LOAD_IV: n_chain   = s_axis_tdata;
                default:                    n_pending = n_pending;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain   <= '0;
            r_pending <= 1'b0;
        end else begin
            r_chain   <= n_chain;
            r_pending <= n_pending;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= w[NUM_ROUNDS].vld;
        end
        if (adv) begin
            r_out_data <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- sim/tb_gost_block_cipher_ecb_cbc.sv -----
`timescale 1ns / 1ps

module tb_gost_block_cipher_ecb_cbc;
    import gost_bc_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RST_CYCLES     = 6;
    localparam int DRAIN_TAIL     = 40;    // covers a word's trip through the row and the output register
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;

    // Mode codes the block takes and drops
    localparam logic [2:0] MODE_RSVD_5 = 3'd5;
    localparam logic [2:0] MODE_RSVD_7 = 3'd7;
    localparam logic [2:0] MODE_RSVD_6 = 3'd6;

    // Substitution rows; row 0 works on the top nibble
    localparam bit [3:0] SUB_TAB [8][16] = '{
        '{14, 4, 13, 1, 2, 15, 11, 8, 3, 10, 6, 12, 5, 9, 0, 7},
        '{15, 1, 8, 14, 6, 11, 3, 4, 9, 7, 2, 13, 12, 0, 5, 10},
        '{10, 0, 9, 14, 6, 3, 15, 5, 1, 13, 12, 7, 11, 4, 2, 8},
        '{7, 13, 14, 3, 0, 6, 9, 10, 1, 2, 8, 5, 11, 12, 4, 15},
        '{2, 12, 4, 1, 7, 10, 11, 6, 8, 5, 3, 15, 13, 0, 14, 9},
        '{12, 1, 10, 15, 9, 2, 6, 8, 0, 13, 3, 4, 14, 7, 5, 11},
        '{4, 11, 2, 14, 15, 0, 8, 13, 3, 12, 9, 7, 5, 10, 6, 1},
        '{13, 2, 8, 4, 6, 15, 11, 1, 10, 9, 3, 14, 5, 0, 12, 7}
    };

    // One directed word: nres is the number of output words it gives
    typedef struct {
        logic [2:0]  mode;
        logic [63:0] blk;
        int          nres;
    } t_vec;

    t_vec dir_tab [20] = '{
        '{MODE_ECB_ENC, 64'h0000_0000_0000_0000, 1},
        '{MODE_ECB_ENC, 64'hFFFF_FFFF_FFFF_FFFF, 1},
        '{MODE_ECB_DEC, 64'h0000_0000_0000_0000, 1},
        '{MODE_ECB_DEC, 64'hFFFF_FFFF_FFFF_FFFF, 1},
        // chaining value still zero from reset
        '{MODE_CBC_ENC, 64'h0000_0000_0000_0000, 1},
        '{MODE_CBC_DEC, 64'hFFFF_FFFF_FFFF_FFFF, 1},
        '{MODE_LOAD_IV, 64'hFFFF_FFFF_FFFF_FFFF, 0},
        '{MODE_CBC_ENC, 64'h0000_0000_0000_0000, 1},
        '{MODE_CBC_ENC, 64'h0123_4567_89AB_CDEF, 1},
        '{MODE_LOAD_IV, 64'hFFFF_FFFF_FFFF_FFFF, 0},
        '{MODE_CBC_DEC, 64'h0000_0000_0000_0000, 1},
        '{MODE_CBC_DEC, 64'hFEDC_BA98_7654_3210, 1},
        // undefined modes are swallowed
        '{MODE_RSVD_5,  64'hFFFF_FFFF_FFFF_FFFF, 0},
        '{MODE_RSVD_6,  64'h0000_0000_0000_0000, 0},
        '{MODE_RSVD_7,  64'h5555_5555_AAAA_AAAA, 0},
        '{MODE_ECB_ENC, 64'h8000_0000_0000_0001, 1},
        '{MODE_ECB_DEC, 64'h0000_0000_FFFF_FFFF, 1},
        '{MODE_LOAD_IV, 64'h0000_0000_0000_0000, 0},
        '{MODE_CBC_DEC, 64'hFFFF_FFFF_0000_0000, 1},
        '{MODE_ECB_ENC, 64'hAAAA_AAAA_5555_5555, 1}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [63:0]          s_axis_tdata;
    logic [2:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [63:0]          m_axis_tdata;

    // Predictor state
    bit [31:0]   key_reg [8];
    bit [63:0]   chain_reg;
    bit [63:0]   exp_blocks [$];
    int          drv_nres;      // -1: let the predictor decide
    int          mismatches;
    int          stall_cycles;
    bit          src_idle_on;
    bit          snk_idle_on;
    bit          long_hold_req;

    gost_block_cipher_ecb_cbc u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Substitute nibbles, rotate left by 11
    function automatic bit [31:0] gost_mix(input bit [31:0] x);
        bit [31:0] w;
        for (int i = 0; i < 8; i++) begin
            w[28 - 4*i +: 4] = SUB_TAB[i][x[28 - 4*i +: 4]];
        end
        return {w[20:0], w[31:21]};
    endfunction

    // 32 rounds; result holds n2 in the low word and n1 in the high word
    function automatic bit [63:0] gost_cipher(input bit [63:0] blk, input bit dec);
        bit [31:0] n1;
        bit [31:0] n2;
        bit        fwd;
        int        ki;
        n1 = blk[31:0];
        n2 = blk[63:32];
        for (int r = 0; r < 32; r++) begin
            fwd = dec ? (r < 8) : (r < 24);
            ki  = fwd ? (r % 8) : (7 - r % 8);
            if (r % 2 == 0) begin
                n2 ^= gost_mix(n1 + key_reg[ki]);
            end else begin
                n1 ^= gost_mix(n2 + key_reg[ki]);
            end
        end
        return {n1, n2};
    endfunction

    // Work out one word and advance the chaining value
    task automatic predict_word(input logic [2:0] mode, input logic [63:0] blk,
                                output bit has, output bit [63:0] res);
        has = 1'b1;
        res = '0;
        case (mode)
            MODE_ECB_ENC: res = gost_cipher(blk, 1'b0);
            MODE_ECB_DEC: res = gost_cipher(blk, 1'b1);
            MODE_CBC_ENC: begin
                res       = gost_cipher(blk ^ chain_reg, 1'b0);
                chain_reg = res;
            end
            MODE_CBC_DEC: begin
                res       = gost_cipher(blk, 1'b1) ^ chain_reg;
                chain_reg = blk;
            end
            MODE_LOAD_IV: begin
                chain_reg = blk;
                has       = 1'b0;
            end
            default: has = 1'b0;
        endcase
    endtask

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        if (mismatches < 10) begin
            $display("%0t: %s: expected %016h, got %016h", $time, what, want, got);
        end
        mismatches++;
    endtask

    // Track key writes, predict accepted words, check output words
    always @(posedge i_clk) begin
        bit        has;
        bit [63:0] res;
        bit [63:0] want;
        if (!i_rst_n) begin
            key_reg   = '{default: '0};
            chain_reg = '0;
            exp_blocks.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready && i_cfg_index < NUM_KEYS) begin
                key_reg[i_cfg_index[2:0]] = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_word(s_axis_tuser, s_axis_tdata, has, res);
                if (drv_nres >= 0) begin
                    has = (drv_nres > 0);
                end
                if (has) begin
                    exp_blocks.push_back(res);
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (exp_blocks.size() == 0) begin
                    note_mismatch("word with none expected", 64'h0, m_axis_tdata);
                end else begin
                    want = exp_blocks.pop_front();
                    if (m_axis_tdata !== want) begin
                        note_mismatch("block_out", want, m_axis_tdata);
                    end
                end
            end
        end
    end

    // End the run when no word moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles", stall_cycles);
            $display("end of test: mismatches");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Output side: random stalls, one long hold on request
    initial begin
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (long_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold_req = 1'b0;
            end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    function automatic bit [63:0] rand_block();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Offer one word, maybe after a gap; return at the falling edge after it is taken
    task automatic send_word(input logic [2:0] mode, input logic [63:0] blk, input int nres);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= blk;
        drv_nres      <= nres;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Hold the input until every word is back and the row has emptied
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (exp_blocks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(negedge i_clk);
    endtask

    // Write all eight key words, then one index past the end
    task automatic program_keys(input bit [31:0] fill, input bit scramble);
        for (int i = 0; i <= NUM_KEYS; i++) begin
            i_cfg_valid <= 1'b1;
            if (i < NUM_KEYS) begin
                i_cfg_index <= CFG_IDX_W'(i);
                i_cfg_data  <= !scramble ? fill
                             : ($urandom_range(0, 3) == 0 ? 32'h0 : $urandom);
            end else begin
                i_cfg_index <= CFG_IDX_W'($urandom_range(NUM_KEYS, (1 << CFG_IDX_W) - 1));
                i_cfg_data  <= $urandom;
            end
            do @(posedge i_clk); while (!o_cfg_ready);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Load an IV, encrypt a short chain, reload it and decrypt the chain back
    task automatic cbc_round_trip(output int count);
        int        len;
        bit [63:0] iv;
        bit [63:0] link;
        bit [63:0] pt [8];
        bit [63:0] ct [8];
        len  = $urandom_range(2, 8);
        iv   = rand_block();
        link = iv;
        for (int i = 0; i < len; i++) begin
            pt[i] = rand_block();
            ct[i] = gost_cipher(pt[i] ^ link, 1'b0);
            link  = ct[i];
        end
        send_word(MODE_LOAD_IV, iv, -1);
        for (int i = 0; i < len; i++) send_word(MODE_CBC_ENC, pt[i], -1);
        send_word(MODE_LOAD_IV, iv, -1);
        for (int i = 0; i < len; i++) send_word(MODE_CBC_DEC, ct[i], -1);
        count = 2 * len + 2;
    endtask

    // Random words until n of them were ones the block acts on
    task automatic run_random(input int n);
        int         live;
        int         pick;
        int         cnt;
        logic [2:0] mode;
        live = 0;
        while (live < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                cbc_round_trip(cnt);
                live += cnt;
            end else if (pick < 96) begin
                mode = (pick < 31) ? MODE_ECB_ENC :
                       (pick < 52) ? MODE_ECB_DEC :
                       (pick < 70) ? MODE_CBC_ENC :
                       (pick < 88) ? MODE_CBC_DEC : MODE_LOAD_IV;
                send_word(mode, rand_block(), -1);
                live++;
            end else begin
                send_word(3'($urandom_range(MODE_RSVD_5, MODE_RSVD_7)), rand_block(), -1);
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_ECB_ENC;
        drv_nres      = -1;
        mismatches    = 0;
        stall_cycles  = 0;
        src_idle_on   = 1'b1;
        snk_idle_on   = 1'b1;
        long_hold_req = 1'b0;
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words on the all-zero key from reset
        foreach (dir_tab[i]) send_word(dir_tab[i].mode, dir_tab[i].blk, dir_tab[i].nres);
        drain();

        // All-ones key; fill the row against a held output, then pause the input
        program_keys(32'hFFFF_FFFF, 1'b0);
        run_random(30);
        long_hold_req = 1'b1;
        for (int i = 0; i < 60; i++) begin
            send_word($urandom_range(0, 1) ? MODE_ECB_DEC : MODE_ECB_ENC, rand_block(), -1);
        end
        drain();
        run_random(30);
        drain();

        // Random keys
        program_keys(32'h0, 1'b1);
        run_random(130);
        drain();
        program_keys(32'h0, 1'b1);
        run_random(130);
        drain();

        // Last stretch at full rate on both sides
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        program_keys(32'h0, 1'b1);
        run_random(100);
        drain();

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
